/* rtl/elsf_pkg.sv */
// ----------------------------------------------------------------------------
// elsf_pkg
// Types and constants shared by the edge line least-squares fit block.
// ----------------------------------------------------------------------------
package elsf_pkg;

  // One image row in, one fit result out.
  typedef struct packed {
    logic [7:0] edge_col;
    logic [7:0] col_below;
    logic [7:0] row_index;
    logic       last_point;
  } row_req_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [7:0]         point_count;
    logic               degenerate;
  } fit_req_t;

  // Line modes; code 3 behaves as middle.
  typedef enum logic [1:0] {
    LM_LEFT   = 2'd0,
    LM_RIGHT  = 2'd1,
    LM_MIDDLE = 2'd2
  } line_mode_e;

  // Register map (index = paddr[2]).
  typedef enum logic {
    REG_LINE_MODE = 1'b0,
    REG_LOST_COL  = 1'b1
  } reg_idx_e;

  localparam int          APB_ADDR_W   = 3;
  localparam logic [1:0]  LINE_MODE_RST = 2'd2;
  localparam logic [7:0]  LOST_COL_RST  = 8'd140;

  // Datapath widths, sized for the largest point count (256) and 8-bit columns.
  localparam int MUL_A_W = 34;                 // num/den and the wide sums
  localparam int MUL_B_W = 17;                 // n, sum_x, sum_y
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WIDE_W  = 52;                 // accumulator / dividend
  localparam int DSR_W   = 41;                 // divisor (n*den < 2^40)
  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // Multiply-accumulate program, run in this order.
  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,   // acc  = n*Sxx
    OP_SX_SX  = 3'd1,   // den  = acc - Sx*Sx
    OP_N_SXY  = 3'd2,   // acc  = n*Sxy
    OP_SX_SY  = 3'd3,   // num  = acc - Sx*Sy
    OP_SY_DEN = 3'd4,   // acc  = Sy*den
    OP_SX_NUM = 3'd5,   // icn  = acc - num*Sx
    OP_N_DEN  = 3'd6    // dvs  = n*den
  } mac_op_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic load;
  } mac_ctl_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] dividend;
    logic [DSR_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [Q_W-1:0] value;
  } div_rsp_t;

endpackage

/* rtl/elsf_accum.sv */
// ----------------------------------------------------------------------------
// elsf_accum
// Picks the x column of a row and keeps count and the running sums.
// ----------------------------------------------------------------------------
module elsf_accum #(
  parameter int MAX_POINTS = 128,
  parameter int COL_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                add_i,
  input  logic                                clr_i,
  input  elsf_pkg::row_req_t                  row_i,
  input  logic [1:0]                          line_mode_i,
  input  logic [7:0]                          lost_col_i,
  output logic [$clog2(MAX_POINTS+1)-1:0]     count_o,
  output logic [$clog2(MAX_POINTS+1)+7:0]     sum_x_o,
  output logic [$clog2(MAX_POINTS+1)+7:0]     sum_y_o,
  output logic [$clog2(MAX_POINTS+1)+15:0]    sum_xx_o,
  output logic [$clog2(MAX_POINTS+1)+15:0]    sum_xy_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = CNT_W + 8;
  localparam int SXX_W = CNT_W + 16;
  localparam logic [7:0] X_MASK = 8'((1 << COL_BITS) - 1);

  logic [CNT_W-1:0] count_q;
  logic [SX_W-1:0]  sum_x_q, sum_y_q;
  logic [SXX_W-1:0] sum_xx_q, sum_xy_q;
  logic [7:0]       x_sel, x;
  logic [15:0]      xx, xy;
  logic             room;

  always_comb begin
    x_sel = row_i.edge_col;
    case (line_mode_i)
      elsf_pkg::LM_LEFT: begin
        if (row_i.edge_col == 8'd0) x_sel = row_i.col_below;
      end
      elsf_pkg::LM_RIGHT: begin
        if (row_i.edge_col == lost_col_i) x_sel = row_i.col_below;
      end
      default: x_sel = row_i.edge_col;
    endcase
  end

  assign x    = x_sel & X_MASK;
  assign xx   = 16'(x) * 16'(x);
  assign xy   = 16'(x) * 16'(row_i.row_index);
  assign room = (count_q < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
    end else if (clr_i) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
    end else if (add_i && room) begin
      count_q  <= count_q + CNT_W'(1);
      sum_x_q  <= sum_x_q + SX_W'(x);
      sum_y_q  <= sum_y_q + SX_W'(row_i.row_index);
      sum_xx_q <= sum_xx_q + SXX_W'(xx);
      sum_xy_q <= sum_xy_q + SXX_W'(xy);
    end
  end

  assign count_o  = count_q;
  assign sum_x_o  = sum_x_q;
  assign sum_y_o  = sum_y_q;
  assign sum_xx_o = sum_xx_q;
  assign sum_xy_o = sum_xy_q;

endmodule

/* rtl/elsf_mac.sv */
// ----------------------------------------------------------------------------
// elsf_mac
// Shared multiplier with a registered product and a load/subtract accumulator.
// ----------------------------------------------------------------------------
module elsf_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  elsf_pkg::mac_ctl_t                     ctl_i,
  input  logic signed [elsf_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [elsf_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [elsf_pkg::WIDE_W-1:0]     res_o
);

  logic signed [elsf_pkg::PROD_W-1:0] prod_q;
  logic signed [elsf_pkg::WIDE_W-1:0] acc_q;
  logic signed [elsf_pkg::WIDE_W-1:0] prod_ext;

  assign prod_ext = elsf_pkg::WIDE_W'(prod_q);
  assign res_o    = ctl_i.load ? prod_ext : acc_q - prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctl_i.mul_en) prod_q <= a_i * b_i;
      if (ctl_i.acc_en) acc_q  <= res_o;
    end
  end

endmodule

/* rtl/elsf_div.sv */
// ----------------------------------------------------------------------------
// elsf_div
// Radix-2 restoring divider: signed dividend by positive divisor, Q16.16
// quotient rounded toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module elsf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  elsf_pkg::div_req_t req_i,
  output elsf_pkg::div_rsp_t rsp_o
);

  localparam int HI_W  = elsf_pkg::WIDE_W - elsf_pkg::FRAC_W;
  localparam int CMP_W = HI_W + elsf_pkg::DSR_W;
  localparam int STP_W = $clog2(elsf_pkg::Q_W);

  typedef enum logic [3:0] {
    DV_IDLE  = 4'b0001,
    DV_CHECK = 4'b0010,
    DV_STEP  = 4'b0100,
    DV_DONE  = 4'b1000
  } dv_state_e;

  dv_state_e                         state_q, state_d;
  logic [STP_W-1:0]                  step_q;
  logic                              neg_q, ovf_q, done_q;
  logic [HI_W-1:0]                   hi_q;
  logic [elsf_pkg::Q_W-1:0]          lo_q, quo_q;
  logic [elsf_pkg::DSR_W-1:0]        rem_q, dvs_q;
  logic signed [elsf_pkg::Q_W-1:0]   value_q, sat;
  logic [elsf_pkg::WIDE_W-1:0]       mag;
  logic [elsf_pkg::DSR_W:0]          sh, diff;
  logic                              ge, hi_ovf;

  assign mag    = req_i.dividend[elsf_pkg::WIDE_W-1] ? $unsigned(-req_i.dividend)
                                                     : $unsigned(req_i.dividend);
  assign hi_ovf = CMP_W'(hi_q) >= CMP_W'(dvs_q);
  assign sh     = {rem_q, lo_q[elsf_pkg::Q_W-1]};
  assign diff   = sh - {1'b0, dvs_q};
  assign ge     = (sh >= {1'b0, dvs_q});

  always_comb begin
    if (neg_q) begin
      if (ovf_q || quo_q > $unsigned(elsf_pkg::Q_MIN)) sat = elsf_pkg::Q_MIN;
      else                                              sat = -$signed(quo_q);
    end else begin
      if (ovf_q || quo_q[elsf_pkg::Q_W-1]) sat = elsf_pkg::Q_MAX;
      else                                 sat = $signed(quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE:  if (req_i.start) state_d = DV_CHECK;
      DV_CHECK: state_d = hi_ovf ? DV_DONE : DV_STEP;
      DV_STEP:  if (step_q == STP_W'(elsf_pkg::Q_W - 1)) state_d = DV_DONE;
      DV_DONE:  state_d = DV_IDLE;
      default:  state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DV_DONE);
      if (state_q == DV_STEP) step_q <= step_q + STP_W'(1);
      else                    step_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          neg_q <= req_i.dividend[elsf_pkg::WIDE_W-1];
          hi_q  <= mag[elsf_pkg::WIDE_W-1:elsf_pkg::FRAC_W];
          lo_q  <= {mag[elsf_pkg::FRAC_W-1:0], {(elsf_pkg::Q_W-elsf_pkg::FRAC_W){1'b0}}};
          dvs_q <= req_i.divisor;
          ovf_q <= 1'b0;
        end
      end
      DV_CHECK: begin
        ovf_q <= hi_ovf;
        rem_q <= elsf_pkg::DSR_W'(hi_q);
        quo_q <= '0;
      end
      DV_STEP: begin
        rem_q <= ge ? elsf_pkg::DSR_W'(diff) : elsf_pkg::DSR_W'(sh);
        quo_q <= {quo_q[elsf_pkg::Q_W-2:0], ge};
        lo_q  <= {lo_q[elsf_pkg::Q_W-2:0], 1'b0};
      end
      DV_DONE: value_q <= sat;
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;

endmodule

/* rtl/edge_line_least_squares_fit_top.sv */
// ----------------------------------------------------------------------------
// edge_line_least_squares_fit_top
// Least-squares line fit over edge rows, slope and intercept in Q16.16.
//
// Throughput: a row without the last flag is taken every cycle while idle. A
//   last row holds row_stall_o high until its fit enters the output register.
// Sequence: a last row starts the seven multiply/accumulate steps, then the
//   two divisions run on the shared one-bit-per-cycle divider, then the output
//   register is loaded. A quotient whose high part is not below the divisor
//   skips the bit steps and clamps; zero x spread skips the slope division.
// Reset: rst_ni clears sums, sequencer and output valid; line_mode = 2,
//   lost_right_col = 140. No clearing pass is needed.
// ----------------------------------------------------------------------------
module edge_line_least_squares_fit_top #(
  parameter int MAX_POINTS = 128,
  parameter int COL_BITS   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [elsf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // row requests in
  input  logic                              row_valid_i,
  output logic                              row_stall_o,
  input  elsf_pkg::row_req_t                row_req_i,
  // fit requests out
  output logic                              fit_valid_o,
  input  logic                              fit_stall_i,
  output elsf_pkg::fit_req_t                fit_req_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = CNT_W + 8;
  localparam int SXX_W = CNT_W + 16;

  // Sequencer: seven MUL/ADD pairs, then the slope division (skipped for zero x spread) and the intercept division.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ADD  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } seq_state_e;

  typedef enum logic {
    DS_SLOPE = 1'b0,
    DS_ICEPT = 1'b1
  } div_sel_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0] line_mode_q;
  logic [7:0] lost_col_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= elsf_pkg::LINE_MODE_RST;
      lost_col_q  <= elsf_pkg::LOST_COL_RST;
    end else if (cfg_wr) begin
      case (elsf_pkg::reg_idx_e'(paddr[2]))
        elsf_pkg::REG_LINE_MODE: line_mode_q <= pwdata[1:0];
        elsf_pkg::REG_LOST_COL:  lost_col_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (elsf_pkg::reg_idx_e'(paddr[2]))
      elsf_pkg::REG_LINE_MODE: prdata = {30'd0, line_mode_q};
      elsf_pkg::REG_LOST_COL:  prdata = {24'd0, lost_col_q};
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  seq_state_e          state_q, state_d;
  elsf_pkg::mac_op_e   op_q;
  div_sel_e            div_sel_q;
  logic                degen_q;
  logic                fit_valid_q;
  elsf_pkg::fit_req_t  fit_q;
  logic                row_accept, fit_free, last_op, emit;

  // Rows are taken only while the sequencer idles; a waiting result does
  // not block accumulation of the next range.
  assign row_stall_o = (state_q != S_IDLE);
  assign row_accept  = row_valid_i && !row_stall_o;
  assign fit_free    = !fit_valid_q || !fit_stall_i;
  assign last_op     = (op_q == elsf_pkg::OP_N_DEN);
  assign emit        = (state_q == S_OUT) && fit_free;

  // --------------------------------------------------------------------------
  // Row accumulation
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] count;
  logic [SX_W-1:0]  sum_x, sum_y;
  logic [SXX_W-1:0] sum_xx, sum_xy;

  elsf_accum #(
    .MAX_POINTS (MAX_POINTS),
    .COL_BITS   (COL_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .add_i       (row_accept),
    .clr_i       (emit),
    .row_i       (row_req_i),
    .line_mode_i (line_mode_q),
    .lost_col_i  (lost_col_q),
    .count_o     (count),
    .sum_x_o     (sum_x),
    .sum_y_o     (sum_y),
    .sum_xx_o    (sum_xx),
    .sum_xy_o    (sum_xy)
  );

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate
  // --------------------------------------------------------------------------
  logic signed [elsf_pkg::MUL_A_W-1:0] den_q, num_q, mac_a;
  logic signed [elsf_pkg::MUL_B_W-1:0] mac_b;
  logic signed [elsf_pkg::WIDE_W-1:0]  mac_res, icn_q;
  logic [elsf_pkg::DSR_W-1:0]          dvs_q;
  elsf_pkg::mac_ctl_t                  mac_ctl;

  logic signed [elsf_pkg::MUL_A_W-1:0] sx_a, sxx_a, sxy_a;
  logic signed [elsf_pkg::MUL_B_W-1:0] n_b, sx_b, sy_b;

  assign sx_a  = $signed(elsf_pkg::MUL_A_W'(sum_x));
  assign sxx_a = $signed(elsf_pkg::MUL_A_W'(sum_xx));
  assign sxy_a = $signed(elsf_pkg::MUL_A_W'(sum_xy));
  assign n_b   = $signed(elsf_pkg::MUL_B_W'(count));
  assign sx_b  = $signed(elsf_pkg::MUL_B_W'(sum_x));
  assign sy_b  = $signed(elsf_pkg::MUL_B_W'(sum_y));

  always_comb begin
    case (op_q)
      elsf_pkg::OP_N_SXX:  begin mac_a = sxx_a; mac_b = n_b;  end
      elsf_pkg::OP_SX_SX:  begin mac_a = sx_a;  mac_b = sx_b; end
      elsf_pkg::OP_N_SXY:  begin mac_a = sxy_a; mac_b = n_b;  end
      elsf_pkg::OP_SX_SY:  begin mac_a = sx_a;  mac_b = sy_b; end
      elsf_pkg::OP_SY_DEN: begin mac_a = den_q; mac_b = sy_b; end
      elsf_pkg::OP_SX_NUM: begin mac_a = num_q; mac_b = sx_b; end
      elsf_pkg::OP_N_DEN:  begin mac_a = den_q; mac_b = n_b;  end
      default:             begin mac_a = '0;    mac_b = '0;   end
    endcase
  end

  // Even steps start a new term, odd steps subtract the product.
  assign mac_ctl.mul_en = (state_q == S_MUL);
  assign mac_ctl.acc_en = (state_q == S_ADD);
  assign mac_ctl.load   = (op_q == elsf_pkg::OP_N_SXX) || (op_q == elsf_pkg::OP_N_SXY) ||
                          (op_q == elsf_pkg::OP_SY_DEN) || (op_q == elsf_pkg::OP_N_DEN);

  elsf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .res_o  (mac_res)
  );

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  elsf_pkg::div_req_t div_req;
  elsf_pkg::div_rsp_t div_rsp;

  // Slope = num/den. Intercept = (Sy*den - num*Sx)/(n*den), or Sy/n when
  // the x spread is zero.
  always_comb begin
    div_req.start = (state_q == S_DIV);
    if (div_sel_q == DS_SLOPE) begin
      div_req.dividend = elsf_pkg::WIDE_W'(num_q);
      div_req.divisor  = elsf_pkg::DSR_W'($unsigned(den_q));
    end else if (degen_q) begin
      div_req.dividend = $signed(elsf_pkg::WIDE_W'(sum_y));
      div_req.divisor  = elsf_pkg::DSR_W'(count);
    end else begin
      div_req.dividend = icn_q;
      div_req.divisor  = dvs_q;
    end
  end

  elsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (row_accept && row_req_i.last_point) state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = last_op ? S_DIV : S_MUL;
      S_DIV:  state_d = S_WAIT;
      S_WAIT: begin
        if (div_rsp.done) state_d = (div_sel_q == DS_SLOPE) ? S_DIV : S_OUT;
      end
      S_OUT:  if (fit_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= elsf_pkg::OP_N_SXX;
      div_sel_q   <= DS_SLOPE;
      degen_q     <= 1'b0;
      fit_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == S_IDLE) begin
        op_q <= elsf_pkg::OP_N_SXX;
      end else if (state_q == S_ADD && !last_op) begin
        op_q <= elsf_pkg::mac_op_e'(op_q + 3'd1);
      end

      // zero spread: skip the slope division
      if (state_q == S_ADD && last_op) begin
        degen_q   <= (den_q == '0);
        div_sel_q <= (den_q == '0) ? DS_ICEPT : DS_SLOPE;
      end else if (state_q == S_WAIT && div_rsp.done) begin
        div_sel_q <= DS_ICEPT;
      end

      if (emit)            fit_valid_q <= 1'b1;
      else if (!fit_stall_i) fit_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic signed [elsf_pkg::Q_W-1:0] slope_q, icept_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADD) begin
      case (op_q)
        elsf_pkg::OP_SX_SX:  den_q <= elsf_pkg::MUL_A_W'(mac_res);
        elsf_pkg::OP_SX_SY:  num_q <= elsf_pkg::MUL_A_W'(mac_res);
        elsf_pkg::OP_SX_NUM: icn_q <= mac_res;
        elsf_pkg::OP_N_DEN:  dvs_q <= $unsigned(elsf_pkg::DSR_W'(mac_res));
        default: ;
      endcase
      if (last_op && den_q == '0) slope_q <= '0;
    end

    if (state_q == S_WAIT && div_rsp.done) begin
      if (div_sel_q == DS_SLOPE) slope_q <= div_rsp.value;
      else                       icept_q <= div_rsp.value;
    end

    if (emit) begin
      fit_q.slope       <= slope_q;
      fit_q.intercept   <= icept_q;
      fit_q.point_count <= 8'(count);
      fit_q.degenerate  <= degen_q;
    end
  end

  assign fit_valid_o = fit_valid_q;
  assign fit_req_o   = fit_q;

endmodule

/* rtl/elsf_checker.sv */
// ----------------------------------------------------------------------------
// elsf_checker
// Port-level checks for the edge line fit block, bound to the top level.
// ----------------------------------------------------------------------------
module elsf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               row_valid_i,
  input logic               row_stall_o,
  input elsf_pkg::row_req_t row_req_i,
  input logic               fit_valid_o,
  input logic               fit_stall_i,
  input elsf_pkg::fit_req_t fit_req_o
);

  // stalled result holds
  a_fit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_valid_o && fit_stall_i |=> fit_valid_o && $stable(fit_req_o))
    else $error("fit request changed while stalled");

  // last row starts the fit, so the input stalls next
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_i && !row_stall_o && row_req_i.last_point |=> row_stall_o)
    else $error("no stall after last row");

  // ordinary rows go at full rate
  a_row_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_i && !row_stall_o && !row_req_i.last_point |=> !row_stall_o)
    else $error("stall after ordinary row");

  // a new result only comes out of a computation
  a_fit_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fit_valid_o) |-> $past(row_stall_o))
    else $error("fit request without computation");

  // zero spread forces slope to zero
  a_degen_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_valid_o && fit_req_o.degenerate |-> fit_req_o.slope == 32'sd0)
    else $error("degenerate fit with nonzero slope");

endmodule

bind edge_line_least_squares_fit_top elsf_checker u_elsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .row_valid_i (row_valid_i),
  .row_stall_o (row_stall_o),
  .row_req_i   (row_req_i),
  .fit_valid_o (fit_valid_o),
  .fit_stall_i (fit_stall_i),
  .fit_req_o   (fit_req_o)
);
